/* rtl/wpgr_pkg.sv */
// ----------------------------------------------------------------------------
// wpgr_pkg
// Shared types, constants and the exponential ROM of the peak refit core.
// ----------------------------------------------------------------------------
package wpgr_pkg;

    localparam int MAX_LENGTH = 8192;
    localparam int MAX_PEAKS  = 128;
    localparam int EXP_DEPTH  = 256;

    localparam int LEN_W  = 14;
    localparam int TICK_W = 13;
    localparam int SAMP_W = 16;
    localparam int AREA_W = 28;
    localparam int CNT_W  = 8;
    localparam int ADDR_W = 7;
    localparam int G_W    = 17;

    localparam logic [LEN_W-1:0]  LEN_RESET = 14'd6400;
    localparam logic [LEN_W-1:0]  LEN_MIN   = 14'd4;
    localparam logic [AREA_W-1:0] AREA_MAX  = {AREA_W{1'b1}};
    localparam logic [16:0]       GAIN_Q16  = 17'd130725;
    localparam logic [14:0]       VALUE_MAX = 15'd32767;
    localparam logic [7:0]        IDX_SCALE = 8'd200;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_READ = 1'b1
    } t_kind;

    typedef struct packed {
        logic                     kind;
        logic signed [SAMP_W-1:0] sample;
        logic [TICK_W-1:0]        tick;
    } t_in;

    typedef struct packed {
        logic signed [15:0] value;
        logic               ready_res;
        logic [CNT_W-1:0]   peak_total;
    } t_out;

    // front status seen by the back end
    typedef struct packed {
        logic              scan_done;
        logic [CNT_W-1:0]  count;
        logic [LEN_W-1:0]  len;
    } t_fe_stat;

    // peak table write request
    typedef struct packed {
        logic              start_we;
        logic              stop_we;
        logic [ADDR_W-1:0] addr;
        logic [TICK_W-1:0] start_pos;
        logic [TICK_W-1:0] stop_pos;
        logic [AREA_W-1:0] area;
    } t_pk_wr;

    typedef logic [G_W-1:0] t_exp_rom [EXP_DEPTH];

    // Taylor terms of exp(-4/EXP_DEPTH) in Q32, each truncated
    localparam logic [127:0] EXP_T0  = 128'd1 << 32;
    localparam logic [127:0] EXP_T1  = (EXP_T0  * 128'd4) / 128'(EXP_DEPTH * 1);
    localparam logic [127:0] EXP_T2  = (EXP_T1  * 128'd4) / 128'(EXP_DEPTH * 2);
    localparam logic [127:0] EXP_T3  = (EXP_T2  * 128'd4) / 128'(EXP_DEPTH * 3);
    localparam logic [127:0] EXP_T4  = (EXP_T3  * 128'd4) / 128'(EXP_DEPTH * 4);
    localparam logic [127:0] EXP_T5  = (EXP_T4  * 128'd4) / 128'(EXP_DEPTH * 5);
    localparam logic [127:0] EXP_T6  = (EXP_T5  * 128'd4) / 128'(EXP_DEPTH * 6);
    localparam logic [127:0] EXP_T7  = (EXP_T6  * 128'd4) / 128'(EXP_DEPTH * 7);
    localparam logic [127:0] EXP_T8  = (EXP_T7  * 128'd4) / 128'(EXP_DEPTH * 8);
    localparam logic [127:0] EXP_T9  = (EXP_T8  * 128'd4) / 128'(EXP_DEPTH * 9);
    localparam logic [127:0] EXP_T10 = (EXP_T9  * 128'd4) / 128'(EXP_DEPTH * 10);
    localparam logic [127:0] EXP_T11 = (EXP_T10 * 128'd4) / 128'(EXP_DEPTH * 11);
    localparam logic [127:0] EXP_T12 = (EXP_T11 * 128'd4) / 128'(EXP_DEPTH * 12);
    localparam logic [127:0] EXP_POS = EXP_T0 + EXP_T2 + EXP_T4 + EXP_T6 + EXP_T8
                                       + EXP_T10 + EXP_T12;
    localparam logic [127:0] EXP_NEG = EXP_T1 + EXP_T3 + EXP_T5 + EXP_T7 + EXP_T9
                                       + EXP_T11;
    localparam logic [127:0] EXP_STEP = EXP_POS - EXP_NEG;

    // exp(-4k/EXP_DEPTH) in Q16, built by the Q32 recurrence
    function automatic t_exp_rom gen_exp_rom();
        t_exp_rom     rom;
        logic [127:0] cur;
        cur    = 128'd1 << 32;
        rom[0] = cur[32:16];
        for (int k = 1; k < EXP_DEPTH; k++) begin
            cur    = (cur * EXP_STEP + (128'd1 << 31)) >> 32;
            rom[k] = cur[32:16];
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_G = gen_exp_rom();

endpackage

/* rtl/wpgr_queue.sv */
// ----------------------------------------------------------------------------
// wpgr_queue
// Two-entry queue of read ticks between front and back end.
// ----------------------------------------------------------------------------
module wpgr_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [wpgr_pkg::TICK_W-1:0] i_tick,
    input  logic                        i_pop,
    output logic [wpgr_pkg::TICK_W-1:0] o_tick,
    output logic                        o_full,
    output logic                        o_empty
);
    import wpgr_pkg::*;

    logic [TICK_W-1:0] r_data [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_tick  = r_data[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

/* rtl/wpgr_front.sv */
// ----------------------------------------------------------------------------
// wpgr_front
// Load side: window scan, peak open/close and table writes, length register.
// ----------------------------------------------------------------------------
module wpgr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic signed [wpgr_pkg::SAMP_W-1:0] i_sample,
    input  logic                        i_cfg_we,
    input  logic [wpgr_pkg::LEN_W-1:0]  i_cfg_data,
    output wpgr_pkg::t_fe_stat          o_stat,
    output wpgr_pkg::t_pk_wr            o_wr
);
    import wpgr_pkg::*;

    logic signed [SAMP_W-1:0] r_win [3];
    logic [LEN_W-1:0]         r_pos;
    logic [1:0]               r_skip;
    logic                     r_inpk;
    logic [AREA_W-1:0]        r_acc;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_done;
    logic [LEN_W-1:0]         r_len;

    logic signed [SAMP_W-1:0] c_win [3];
    logic [LEN_W-1:0]         c_pos;
    logic [1:0]               n_skip;
    logic                     n_inpk;
    logic [AREA_W-1:0]        n_acc;
    logic [CNT_W-1:0]         n_cnt;
    logic                     n_done;
    logic [LEN_W-1:0]         n_pos;
    logic                     hit;
    logic signed [17:0]       sum;
    logic [AREA_W:0]          acc_sum;
    logic                     close_main;
    logic                     close_tail;
    logic [LEN_W-1:0]         tail_stop;
    logic [LEN_W-1:0]         main_stop;
    logic [LEN_W-1:0]         cfg_len;
    logic                     room;

    assign o_stat = '{scan_done: r_done, count: r_cnt, len: r_len};

    always_comb begin
        // a load after a finished scan starts a new waveform
        c_win[0] = r_done ? '0 : r_win[0];
        c_win[1] = r_done ? '0 : r_win[1];
        c_win[2] = r_done ? '0 : r_win[2];
        c_pos    = r_done ? '0 : r_pos;
        n_skip   = r_done ? '0 : r_skip;
        n_inpk   = r_done ? 1'b0 : r_inpk;
        n_acc    = r_done ? '0 : r_acc;
        n_cnt    = r_done ? '0 : r_cnt;
        n_done   = 1'b0;
        room     = (n_cnt < CNT_W'(MAX_PEAKS));

        hit = (c_win[0] > 0) && (c_win[1] > 0) && (c_win[2] > 0) && (i_sample > 0);
        sum = 18'(c_win[0]) + 18'(c_win[1]) + 18'(c_win[2]) + 18'(i_sample);
        main_stop  = c_pos - LEN_W'(4);
        close_main = 1'b0;
        o_wr       = '0;
        o_wr.addr  = n_cnt[ADDR_W-1:0];
        o_wr.start_pos = c_pos[TICK_W-1:0] - TICK_W'(3);

        if (c_pos >= LEN_W'(3)) begin
            if (n_skip != 2'd0) begin
                n_skip = n_skip - 2'd1;
            end else if (hit) begin
                if (!n_inpk) begin
                    o_wr.start_we = room;
                    n_acc = '0;
                end
                acc_sum = {1'b0, n_acc} + (AREA_W+1)'(sum[16:0]);
                n_acc   = acc_sum[AREA_W] ? AREA_MAX : acc_sum[AREA_W-1:0];
                n_inpk  = 1'b1;
                n_skip  = 2'd3;
            end else if (n_inpk) begin
                close_main = 1'b1;
            end
        end
        acc_sum = {1'b0, n_acc};

        n_pos      = c_pos + LEN_W'(1);
        tail_stop  = r_len - LEN_W'(4) + LEN_W'(n_skip);
        close_tail = (n_pos >= r_len) && n_inpk && !close_main;
        if (n_pos >= r_len) begin
            n_done = 1'b1;
        end

        if (close_main || close_tail) begin
            o_wr.stop_we  = room;
            o_wr.stop_pos = close_main ? main_stop[TICK_W-1:0] : tail_stop[TICK_W-1:0];
            o_wr.area     = n_acc;
            n_inpk        = 1'b0;
            if (room) begin
                n_cnt = n_cnt + CNT_W'(1);
            end
        end

        if (!i_load) begin
            o_wr.start_we = 1'b0;
            o_wr.stop_we  = 1'b0;
        end

        // clamp length to [4, MAX_LENGTH]
        if (i_cfg_data < LEN_MIN) begin
            cfg_len = LEN_MIN;
        end else if (i_cfg_data > LEN_W'(MAX_LENGTH)) begin
            cfg_len = LEN_W'(MAX_LENGTH);
        end else begin
            cfg_len = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= '0;
            r_win[1] <= '0;
            r_win[2] <= '0;
            r_pos    <= '0;
            r_skip   <= '0;
            r_inpk   <= 1'b0;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_done   <= 1'b0;
            r_len    <= LEN_RESET;
        end else if (i_cfg_we) begin
            r_len    <= cfg_len;
            r_win[0] <= '0;
            r_win[1] <= '0;
            r_win[2] <= '0;
            r_pos    <= '0;
            r_skip   <= '0;
            r_inpk   <= 1'b0;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_done   <= 1'b0;
        end else if (i_load) begin
            r_win[0] <= c_win[1];
            r_win[1] <= c_win[2];
            r_win[2] <= i_sample;
            r_pos    <= n_pos;
            r_skip   <= n_skip;
            r_inpk   <= n_inpk;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_done   <= n_done;
        end
    end

endmodule

/* rtl/wpgr_back.sv */
// ----------------------------------------------------------------------------
// wpgr_back
// Read side: peak table, table search, index and value division, result word.
// ----------------------------------------------------------------------------
module wpgr_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wpgr_pkg::t_pk_wr            i_wr,
    input  wpgr_pkg::t_fe_stat          i_stat,
    input  logic                        i_q_empty,
    input  logic [wpgr_pkg::TICK_W-1:0] i_q_tick,
    output logic                        o_q_pop,
    output logic                        o_busy,
    input  logic                        i_pop,
    output logic                        o_empty,
    output wpgr_pkg::t_out              o_res
);
    import wpgr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_CALC, S_SQR, S_IDIV0, S_IDIV, S_ROM, S_MULG,
        S_MULLO, S_MULHI, S_NORM, S_SAT, S_VDIV, S_DONE
    } t_state;

    logic [TICK_W-1:0] mem_start [MAX_PEAKS];
    logic [TICK_W-1:0] mem_stop  [MAX_PEAKS];
    logic [AREA_W-1:0] mem_area  [MAX_PEAKS];
    logic [TICK_W-1:0] r_rd_start;
    logic [TICK_W-1:0] r_rd_stop;
    logic [AREA_W-1:0] r_rd_area;

    t_state            r_state;
    logic [TICK_W-1:0] r_tick;
    logic [CNT_W-1:0]  r_p;
    logic              r_chk;
    logic [TICK_W-1:0] r_s;
    logic [TICK_W-1:0] r_e;
    logic [AREA_W-1:0] r_area;
    logic [TICK_W-1:0] r_w;
    logic signed [14:0] r_d;
    logic [25:0]       r_d2;
    logic [25:0]       r_w2;
    logic [33:0]       r_rem;
    logic [33:0]       r_div;
    logic [7:0]        r_q;
    logic [3:0]        r_k;
    logic [G_W-1:0]    r_g;
    logic [44:0]       r_prod;
    logic [61:0]       r_num;
    logic [30:0]       r_n;
    logic [14:0]       r_val;
    logic              r_res_valid;
    t_out              r_res;

    logic              match;
    logic [TICK_W:0]   twice;
    logic [62:0]       norm_sum;
    logic [51:0]       d_sq;

    always_ff @(posedge i_clk) begin
        if (i_wr.start_we) begin
            mem_start[i_wr.addr] <= i_wr.start_pos;
        end
        if (i_wr.stop_we) begin
            mem_stop[i_wr.addr] <= i_wr.stop_pos;
            mem_area[i_wr.addr] <= i_wr.area;
        end
        r_rd_start <= mem_start[r_p[ADDR_W-1:0]];
        r_rd_stop  <= mem_stop[r_p[ADDR_W-1:0]];
        r_rd_area  <= mem_area[r_p[ADDR_W-1:0]];
    end

    assign o_q_pop = (r_state == S_IDLE) && !r_res_valid && !i_q_empty;
    assign o_busy  = (r_state != S_IDLE);
    assign o_empty = !r_res_valid;
    assign o_res   = r_res;
    assign match   = r_chk && (r_tick >= r_rd_start) && (r_tick <= r_rd_stop);
    assign twice   = {r_tick - r_s, 1'b0};
    assign norm_sum = {1'b0, r_num} + {19'd0, r_w, 31'd0};
    assign d_sq    = 52'(r_d * r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_p         <= '0;
            r_chk       <= 1'b0;
        end else begin
            if (i_pop && r_res_valid) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_tick <= i_q_tick;
                        r_p    <= '0;
                        r_chk  <= 1'b0;
                        r_val  <= '0;
                        if (!i_stat.scan_done || ({1'b0, i_q_tick} >= i_stat.len)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SRCH;
                        end
                    end
                end
                S_SRCH: begin
                    // read data belongs to entry r_p - 1
                    if (match) begin
                        r_s     <= r_rd_start;
                        r_e     <= r_rd_stop;
                        r_area  <= r_rd_area;
                        r_state <= S_CALC;
                    end else if (r_p == i_stat.count) begin
                        r_state <= S_DONE;
                    end else begin
                        r_p   <= r_p + CNT_W'(1);
                        r_chk <= 1'b1;
                    end
                end
                S_CALC: begin
                    r_w <= r_e - r_s;
                    r_d <= 15'(twice) - 15'(r_e - r_s);
                    if (r_e == r_s) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    r_d2    <= d_sq[25:0];
                    r_w2    <= 26'(r_w * r_w);
                    r_state <= S_IDIV0;
                end
                S_IDIV0: begin
                    r_rem   <= 34'(r_d2 * IDX_SCALE);
                    r_div   <= {1'b0, r_w2, 7'd0};
                    r_q     <= '0;
                    r_k     <= 4'd7;
                    r_state <= S_IDIV;
                end
                S_IDIV: begin
                    if (r_rem >= r_div) begin
                        r_rem        <= r_rem - r_div;
                        r_q[r_k[2:0]] <= 1'b1;
                    end
                    r_div <= r_div >> 1;
                    if (r_k == 4'd0) begin
                        r_state <= S_ROM;
                    end else begin
                        r_k <= r_k - 4'd1;
                    end
                end
                S_ROM: begin
                    r_g     <= EXP_G[r_q];
                    r_state <= S_MULG;
                end
                S_MULG: begin
                    r_prod  <= 45'(r_area * r_g);
                    r_state <= S_MULLO;
                end
                S_MULLO: begin
                    r_num   <= 62'(r_prod[22:0] * GAIN_Q16);
                    r_state <= S_MULHI;
                end
                S_MULHI: begin
                    r_num   <= r_num + {39'(r_prod[44:23] * GAIN_Q16), 23'd0};
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    r_n     <= norm_sum[62:32];
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    if (r_n >= {3'd0, r_w, 15'd0}) begin
                        r_val   <= VALUE_MAX;
                        r_state <= S_DONE;
                    end else begin
                        r_rem   <= {3'd0, r_n};
                        r_div   <= {7'd0, r_w, 14'd0};
                        r_k     <= 4'd14;
                        r_val   <= '0;
                        r_state <= S_VDIV;
                    end
                end
                S_VDIV: begin
                    if (r_rem >= r_div) begin
                        r_rem      <= r_rem - r_div;
                        r_val[r_k] <= 1'b1;
                    end
                    r_div <= r_div >> 1;
                    if (r_k == 4'd0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k <= r_k - 4'd1;
                    end
                end
                S_DONE: begin
                    r_res.value      <= {1'b0, r_val};
                    r_res.ready_res  <= i_stat.scan_done;
                    r_res.peak_total <= i_stat.count;
                    r_res_valid      <= 1'b1;
                    r_state          <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/waveform_peak_gaussian_refit_core.sv */
// ----------------------------------------------------------------------------
// waveform_peak_gaussian_refit_core
// Peak finder on a loaded waveform with Gaussian refit read-back.
// ----------------------------------------------------------------------------
// A load word goes to the front end, which shifts the sample into a
// four-sample window, opens, extends or closes peaks and writes the peak
// table, so loads stream at one per cycle while no read is pending. A read
// word goes into a two-word queue and the back end works it out on its own,
// taking it from the queue once it is idle and its last result is popped. A
// read that comes before the scan is done or points past the length goes
// straight to the done state and posts zero. Otherwise the back end walks
// the peak table one entry per cycle over all peak_total entries; a read
// that misses every peak posts zero. A hit then runs through width and
// offset, the square terms, an 8-step ROM index division, the ROM look-up,
// the area multiply, the gain multiply split into low and high halves, the
// rounding shift, the saturation check, a 15-step value division and the
// result write; a value that saturates skips the division, and a peak of
// zero width posts zero. A result not yet popped holds the next read in the
// queue. Loads wait while a read is queued or in progress, so the table a
// read sees is the one of the waveform loaded before it. Length writes go
// through a one-word channel that is always ready; write only while idle.
// ----------------------------------------------------------------------------
module waveform_peak_gaussian_refit_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  wpgr_pkg::t_in              i_in_word,
    output logic                       empty,
    input  logic                       pop,
    output wpgr_pkg::t_out             o_out_word,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [wpgr_pkg::LEN_W-1:0] i_cfg_data
);
    import wpgr_pkg::*;

    t_fe_stat          fe_stat;
    t_pk_wr            pk_wr;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic [TICK_W-1:0] q_tick;
    logic              be_busy;
    logic              is_read;
    logic              load_acc;
    logic              read_acc;

    // hold loads back while any read is still pending
    assign is_read  = (i_in_word.kind == KIND_READ);
    assign full     = is_read ? q_full : (!q_empty || be_busy);
    assign load_acc = push && !full && !is_read;
    assign read_acc = push && !full && is_read;
    assign cfg_ready = 1'b1;

    wpgr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load_acc),
        .i_sample   (i_in_word.sample),
        .i_cfg_we   (cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_stat     (fe_stat),
        .o_wr       (pk_wr)
    );

    wpgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (read_acc),
        .i_tick  (i_in_word.tick),
        .i_pop   (q_pop),
        .o_tick  (q_tick),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    wpgr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (pk_wr),
        .i_stat    (fe_stat),
        .i_q_empty (q_empty),
        .i_q_tick  (q_tick),
        .o_q_pop   (q_pop),
        .o_busy    (be_busy),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (o_out_word)
    );

endmodule
